// ===== hdl/tha_pkg.sv =====
// Package for the turret heading block: transaction types, register indexes,
// fixed-point widths, angle constants and the arctangent table.
// No dependencies; used by every module of the block.
package tha_pkg;

	localparam int TABLE_LEN  = 24;
	localparam int MAG_W      = 16;
	localparam int FRAC_SHIFT = 24;
	localparam int CW         = 44;
	localparam int ZW         = 28;
	localparam int HW         = 29;
	localparam int ADDR_W     = 4;

	localparam logic signed [HW-1:0] DEG90      = 29'sd94371840;
	localparam logic signed [HW-1:0] DEG180     = 29'sd188743680;
	localparam logic signed [HW-1:0] ROUND_HALF = 29'sd2048;
	localparam logic signed [ZW-1:0] DEG90_Z    = 28'sd94371840;

	localparam logic [1:0] REG_TURRET_X     = 2'd0;
	localparam logic [1:0] REG_TURRET_Y     = 2'd1;
	localparam logic [1:0] REG_ATTACK_RADIUS = 2'd2;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic               has_target;
	} tha_in_t;

	typedef struct packed {
		logic signed [16:0] heading;
		logic               heading_valid;
		logic               in_range;
	} tha_out_t;

	typedef enum logic [2:0] {
		QD_PP,
		QD_NN,
		QD_PN,
		QD_NP,
		QD_ZERO,
		QD_DOWN,
		QD_LEFT,
		QD_RIGHT
	} tha_quad_t;

	typedef struct packed {
		logic      has_target;
		logic      in_range;
		tha_quad_t quad;
	} tha_side_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ZW-1:0] val;
		case (idx)
			5'd0:    val = 28'sd47185920;
			5'd1:    val = 28'sd27855475;
			5'd2:    val = 28'sd14718068;
			5'd3:    val = 28'sd7471121;
			5'd4:    val = 28'sd3750058;
			5'd5:    val = 28'sd1876857;
			5'd6:    val = 28'sd938658;
			5'd7:    val = 28'sd469357;
			5'd8:    val = 28'sd234682;
			5'd9:    val = 28'sd117342;
			5'd10:   val = 28'sd58671;
			5'd11:   val = 28'sd29335;
			5'd12:   val = 28'sd14668;
			5'd13:   val = 28'sd7334;
			5'd14:   val = 28'sd3667;
			5'd15:   val = 28'sd1833;
			5'd16:   val = 28'sd917;
			5'd17:   val = 28'sd458;
			5'd18:   val = 28'sd229;
			5'd19:   val = 28'sd115;
			5'd20:   val = 28'sd57;
			5'd21:   val = 28'sd29;
			5'd22:   val = 28'sd14;
			5'd23:   val = 28'sd7;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== hdl/tha_cordic.sv =====
// Pipelined CORDIC vectoring unit: one register stage per iteration, giving
// atan(p/q) in 2^-20 degree units with a sideband carried alongside.
// Depends on tha_pkg.
module tha_cordic #(
	parameter int ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  tha_pkg::tha_side_t             in_side,
	input  logic [tha_pkg::MAG_W-1:0]      in_p,
	input  logic [tha_pkg::MAG_W-1:0]      in_q,
	output logic                           out_valid,
	output tha_pkg::tha_side_t             out_side,
	output logic signed [tha_pkg::ZW-1:0]  out_z
);

	localparam int PAD = tha_pkg::CW - tha_pkg::MAG_W - tha_pkg::FRAC_SHIFT;

	logic                               v_s    [ITERATIONS];
	logic signed [tha_pkg::CW-1:0]      cx_s   [ITERATIONS];
	logic signed [tha_pkg::CW-1:0]      cy_s   [ITERATIONS];
	logic signed [tha_pkg::ZW-1:0]      z_s    [ITERATIONS];
	tha_pkg::tha_side_t                 side_s [ITERATIONS];

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
		logic signed [tha_pkg::CW-1:0] cx_in;
		logic signed [tha_pkg::CW-1:0] cy_in;
		logic signed [tha_pkg::ZW-1:0] z_in;
		logic signed [tha_pkg::CW-1:0] sx;
		logic signed [tha_pkg::CW-1:0] sy;
		logic signed [tha_pkg::ZW-1:0] ang;
		tha_pkg::tha_side_t            side_in;
		logic                          v_in;

		if (k == 0) begin : g_first
			assign cx_in   = $signed({{PAD{1'b0}}, in_q, {tha_pkg::FRAC_SHIFT{1'b0}}});
			assign cy_in   = $signed({{PAD{1'b0}}, in_p, {tha_pkg::FRAC_SHIFT{1'b0}}});
			assign z_in    = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign cx_in   = cx_s[k-1];
			assign cy_in   = cy_s[k-1];
			assign z_in    = z_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign sx  = cx_in >>> k;
		assign sy  = cy_in >>> k;
		assign ang = tha_pkg::atan_entry(5'(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				if (!cy_in[tha_pkg::CW-1]) begin
					cx_s[k] <= cx_in + sy;
					cy_s[k] <= cy_in - sx;
					z_s[k]  <= z_in + ang;
				end else begin
					cx_s[k] <= cx_in - sy;
					cy_s[k] <= cy_in + sx;
					z_s[k]  <= z_in - ang;
				end
			end
		end
	end

	assign out_valid = v_s[ITERATIONS-1];
	assign out_side  = side_s[ITERATIONS-1];
	assign out_z     = z_s[ITERATIONS-1];

endmodule

// ===== hdl/turret_heading_angle.sv =====
// Top level of the turret heading block: configuration registers, difference,
// quadrant and range stages, the CORDIC pipeline and the heading output stage.
// Depends on tha_pkg and tha_cordic.
//
// A target position arrives as an input transaction on in_valid/in_stall/in_data
// and one result transaction leaves on out_valid/out_stall/out_data for each.
// The user must write the turret position and attack radius over the APB-style
// port only while the block holds no transaction in flight; the block itself
// does not enforce this. pready is always high. Three stages form the
// differences, quadrant, squares and range test, the CORDIC unit spends one
// stage per iteration (capped at 24), and two stages fold the quadrant in and
// round. A new transaction is taken every cycle while the output is not
// stalled. When the receiver stalls a valid result, the whole pipeline holds
// and in_stall rises in the same cycle, so nothing is lost or repeated. Reset
// clears all valid bits and sets the configuration registers to zero.
module turret_heading_angle #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tha_pkg::tha_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tha_pkg::tha_out_t          out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tha_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int ITER_EFF = (ANGLE_ITERATIONS > tha_pkg::TABLE_LEN) ?
		tha_pkg::TABLE_LEN : ANGLE_ITERATIONS;

	logic signed [15:0] turret_x_q;
	logic signed [15:0] turret_y_q;
	logic [11:0]        attack_radius_q;
	logic               cfg_wr;
	logic               adv;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turret_x_q      <= '0;
			turret_y_q      <= '0;
			attack_radius_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tha_pkg::REG_TURRET_X:      turret_x_q      <= pwdata[15:0];
				tha_pkg::REG_TURRET_Y:      turret_y_q      <= pwdata[15:0];
				tha_pkg::REG_ATTACK_RADIUS: attack_radius_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tha_pkg::REG_TURRET_X:      prdata = {{16{turret_x_q[15]}}, turret_x_q};
			tha_pkg::REG_TURRET_Y:      prdata = {{16{turret_y_q[15]}}, turret_y_q};
			tha_pkg::REG_ATTACK_RADIUS: prdata = {20'd0, attack_radius_q};
			default:                    prdata = '0;
		endcase
	end

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic               v_s1;
	logic               has_s1;
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;
	logic [23:0]        r2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			has_s1 <= in_data.has_target;
			dx_s1  <= {turret_x_q[15], turret_x_q} - {in_data.target_x[15], in_data.target_x};
			dy_s1  <= {turret_y_q[15], turret_y_q} - {in_data.target_y[15], in_data.target_y};
			r2_s1  <= {12'd0, attack_radius_q} * {12'd0, attack_radius_q};
		end
	end

	tha_pkg::tha_quad_t            quad;
	logic [tha_pkg::MAG_W-1:0]     p_next;
	logic [tha_pkg::MAG_W-1:0]     q_next;
	logic signed [16:0]            ndx;
	logic signed [16:0]            ndy;
	logic signed [33:0]            sqx_full;
	logic signed [33:0]            sqy_full;

	assign ndx      = -dx_s1;
	assign ndy      = -dy_s1;
	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;

	always_comb begin
		p_next = '0;
		q_next = '0;
		if (dx_s1 > 0 && dy_s1 > 0) begin
			quad   = tha_pkg::QD_PP;
			p_next = dy_s1[15:0];
			q_next = dx_s1[15:0];
		end else if (dx_s1 < 0 && dy_s1 < 0) begin
			quad   = tha_pkg::QD_NN;
			p_next = ndx[15:0];
			q_next = ndy[15:0];
		end else if (dx_s1 > 0 && dy_s1 < 0) begin
			quad   = tha_pkg::QD_PN;
			p_next = dx_s1[15:0];
			q_next = ndy[15:0];
		end else if (dx_s1 < 0 && dy_s1 > 0) begin
			quad   = tha_pkg::QD_NP;
			p_next = dy_s1[15:0];
			q_next = ndx[15:0];
		end else if (dx_s1 == 0 && dy_s1 <= 0) begin
			quad = tha_pkg::QD_ZERO;
		end else if (dx_s1 == 0) begin
			quad = tha_pkg::QD_DOWN;
		end else if (dx_s1 > 0) begin
			quad = tha_pkg::QD_LEFT;
		end else begin
			quad = tha_pkg::QD_RIGHT;
		end
	end

	logic                      v_s2;
	logic                      has_s2;
	tha_pkg::tha_quad_t        quad_s2;
	logic [tha_pkg::MAG_W-1:0] p_s2;
	logic [tha_pkg::MAG_W-1:0] q_s2;
	logic [31:0]               sqx_s2;
	logic [31:0]               sqy_s2;
	logic [23:0]               r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			has_s2  <= has_s1;
			quad_s2 <= quad;
			p_s2    <= p_next;
			q_s2    <= q_next;
			sqx_s2  <= sqx_full[31:0];
			sqy_s2  <= sqy_full[31:0];
			r2_s2   <= r2_s1;
		end
	end

	logic                      v_s3;
	tha_pkg::tha_side_t        side_s3;
	logic [tha_pkg::MAG_W-1:0] p_s3;
	logic [tha_pkg::MAG_W-1:0] q_s3;
	logic [32:0]               d2;

	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.has_target <= has_s2;
			side_s3.quad       <= quad_s2;
			side_s3.in_range   <= (d2 <= {9'd0, r2_s2});
			p_s3               <= p_s2;
			q_s3               <= q_s2;
		end
	end

	logic                          v_cd;
	tha_pkg::tha_side_t            side_cd;
	logic signed [tha_pkg::ZW-1:0] z_cd;

	tha_cordic #(
		.ITERATIONS(ITER_EFF)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.in_side  (side_s3),
		.in_p     (p_s3),
		.in_q     (q_s3),
		.out_valid(v_cd),
		.out_side (side_cd),
		.out_z    (z_cd)
	);

	logic signed [tha_pkg::ZW-1:0] zc;
	logic signed [tha_pkg::HW-1:0] zc_w;
	logic signed [tha_pkg::HW-1:0] h_next;

	always_comb begin
		if (z_cd < 0) begin
			zc = '0;
		end else if (z_cd > tha_pkg::DEG90_Z) begin
			zc = tha_pkg::DEG90_Z;
		end else begin
			zc = z_cd;
		end
		zc_w = {zc[tha_pkg::ZW-1], zc};
		case (side_cd.quad)
			tha_pkg::QD_PP:    h_next = -(zc_w + tha_pkg::DEG90);
			tha_pkg::QD_NN:    h_next = zc_w;
			tha_pkg::QD_PN:    h_next = -zc_w;
			tha_pkg::QD_NP:    h_next = zc_w + tha_pkg::DEG90;
			tha_pkg::QD_DOWN:  h_next = tha_pkg::DEG180;
			tha_pkg::QD_LEFT:  h_next = -tha_pkg::DEG90;
			tha_pkg::QD_RIGHT: h_next = tha_pkg::DEG90;
			default:           h_next = '0;
		endcase
		if (!side_cd.has_target) begin
			h_next = '0;
		end
	end

	logic                          v_s4;
	logic signed [tha_pkg::HW-1:0] h_s4;
	logic                          has_s4;
	logic                          rng_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_cd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s4   <= h_next;
			has_s4 <= side_cd.has_target;
			rng_s4 <= side_cd.in_range;
		end
	end

	logic signed [tha_pkg::HW-1:0] h_rnd;
	logic                          v_s5;
	tha_pkg::tha_out_t             out_s5;

	assign h_rnd = h_s4 + tha_pkg::ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5.heading       <= h_rnd[tha_pkg::HW-1:12];
			out_s5.heading_valid <= has_s4;
			out_s5.in_range      <= rng_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule

// ===== hdl/tha_checker.sv =====
// Port-level checker for the turret heading block, attached by a bind.
// Depends on tha_pkg and on the top level turret_heading_angle.
module tha_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input tha_pkg::tha_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result transaction changed or vanished.");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("Input stall does not follow the output stall.");

	a_no_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.heading_valid |-> out_data.heading == 17'sd0)
		else $error("Heading is nonzero without a target.");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.heading >= -17'sd46080 && out_data.heading <= 17'sd46080)
		else $error("Heading is outside of plus or minus 180 degrees.");

endmodule

bind turret_heading_angle tha_checker u_tha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
